@@ hdl/round_robin_task_picker_defines.svh @@
// Assertion macros for the round-robin task picker.
// Used by the top level only; relies on aclk and aresetn being in scope.
`ifndef ROUND_ROBIN_TASK_PICKER_DEFINES_SVH
`define ROUND_ROBIN_TASK_PICKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RRTP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rrtp_pkg.sv @@
// Shared types and constants for the round-robin task picker.
// No dependencies.
`timescale 1ns / 1ps

package rrtp_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int NUM_W     = $clog2(MAX_TASKS + 1);

    localparam int OP_W    = 2;
    localparam int TIDX_W  = 4;
    localparam int ST_W    = 2;
    localparam int OIDX_W  = 4;
    localparam int ONUM_W  = 5;
    localparam int CNT_W   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_YIELD = 2'd1,
        OP_SET   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        TS_READY   = 2'd0,
        TS_RUNNING = 2'd1,
        TS_OTHER   = 2'd2
    } task_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_BUMP_RD,
        S_BUMP_WR,
        S_CNT_RD,
        S_RESP
    } fsm_state_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic scan_step;
        logic bump_rd;
        logic bump_wr;
        logic cnt_rd;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    hit;
        logic    last;
        logic    out_free;
    } dp_status_t;

endpackage

@@ hdl/rrtp_ctrl.sv @@
// Sequencer for the round-robin task picker.
// Depends on rrtp_pkg.
`timescale 1ns / 1ps

module rrtp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rrtp_pkg::dp_status_t status,
    output rrtp_pkg::dp_cmd_t    cmd
);

    rrtp_pkg::fsm_state_t state_reg;
    rrtp_pkg::fsm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrtp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rrtp_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = rrtp_pkg::S_EXEC;
                end
            end
            rrtp_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
                if (status.op == rrtp_pkg::OP_YIELD) begin
                    state_next = rrtp_pkg::S_SCAN;
                end else begin
                    state_next = rrtp_pkg::S_CNT_RD;
                end
            end
            rrtp_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.hit) begin
                    state_next = rrtp_pkg::S_BUMP_RD;
                end else if (status.last) begin
                    state_next = rrtp_pkg::S_CNT_RD;
                end
            end
            rrtp_pkg::S_BUMP_RD: begin
                cmd.bump_rd = 1'b1;
                state_next  = rrtp_pkg::S_BUMP_WR;
            end
            rrtp_pkg::S_BUMP_WR: begin
                cmd.bump_wr = 1'b1;
                state_next  = rrtp_pkg::S_CNT_RD;
            end
            rrtp_pkg::S_CNT_RD: begin
                cmd.cnt_rd = 1'b1;
                state_next = rrtp_pkg::S_RESP;
            end
            rrtp_pkg::S_RESP: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = rrtp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rrtp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/rrtp_datapath.sv @@
// Task table, pick counter memory and result register for the task picker.
// Depends on rrtp_pkg; driven by rrtp_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module rrtp_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rrtp_pkg::OP_W-1:0]     s_opcode,
    input  logic [rrtp_pkg::TIDX_W-1:0]   s_task_index,
    input  logic [rrtp_pkg::ST_W-1:0]     s_new_state,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic                          m_accepted,
    output logic [rrtp_pkg::OIDX_W-1:0]   m_current_index,
    output logic [rrtp_pkg::ONUM_W-1:0]   m_num_tasks,
    output logic [rrtp_pkg::OIDX_W-1:0]   m_new_task_index,
    output logic [rrtp_pkg::CNT_W-1:0]    m_yield_total,
    output logic [rrtp_pkg::CNT_W-1:0]    m_picked_count,
    input  rrtp_pkg::dp_cmd_t             cmd,
    output rrtp_pkg::dp_status_t          status
);

    localparam int IW = rrtp_pkg::IDX_W;
    localparam int NW = rrtp_pkg::NUM_W;
    localparam int CW = rrtp_pkg::CNT_W;

    rrtp_pkg::opcode_t               op_reg;
    logic [rrtp_pkg::TIDX_W-1:0]     tidx_reg;
    logic [rrtp_pkg::ST_W-1:0]       nst_reg;

    rrtp_pkg::task_state_t           tstate_reg [rrtp_pkg::MAX_TASKS];
    logic [rrtp_pkg::MAX_TASKS-1:0]  cnt_vld_reg;
    logic [CW-1:0]                   cnt_mem [rrtp_pkg::MAX_TASKS];
    logic [CW-1:0]                   cnt_q_reg;
    logic                            cnt_qv_reg;

    logic [NW-1:0]                   ntask_reg;
    logic [IW-1:0]                   cur_reg;
    logic [CW-1:0]                   total_reg;
    logic                            ok_reg;
    logic [IW-1:0]                   newidx_reg;
    logic [IW-1:0]                   ptr_reg;
    logic [NW-1:0]                   off_reg;

    logic                            m_valid_reg;
    logic                            m_accepted_reg;
    logic [rrtp_pkg::OIDX_W-1:0]     m_current_index_reg;
    logic [rrtp_pkg::ONUM_W-1:0]     m_num_tasks_reg;
    logic [rrtp_pkg::OIDX_W-1:0]     m_new_task_index_reg;
    logic [CW-1:0]                   m_yield_total_reg;
    logic [CW-1:0]                   m_picked_count_reg;

    logic                            have_cur;
    logic                            table_full;
    logic                            set_in_range;
    logic [IW-1:0]                   ptr_after;
    logic [IW-1:0]                   cur_after;
    logic [IW-1:0]                   add_idx;
    logic [IW-1:0]                   set_idx;
    rrtp_pkg::task_state_t           set_val;
    logic [CW-1:0]                   cnt_rd_val;

    assign have_cur     = (NW'(cur_reg) < ntask_reg);
    assign table_full   = (ntask_reg >= NW'(rrtp_pkg::MAX_TASKS));
    assign set_in_range = (32'(tidx_reg) < 32'(ntask_reg));
    assign add_idx      = ntask_reg[IW-1:0];
    assign set_idx      = IW'(tidx_reg);
    assign set_val      = (nst_reg > rrtp_pkg::TS_OTHER) ? rrtp_pkg::TS_OTHER
                                                         : rrtp_pkg::task_state_t'(nst_reg);
    // Circular successor within the registered entries.
    assign ptr_after = ((NW'(ptr_reg) + NW'(1)) == ntask_reg) ? '0 : ptr_reg + IW'(1);
    assign cur_after = ((NW'(cur_reg) + NW'(1)) == ntask_reg) ? '0 : cur_reg + IW'(1);
    assign cnt_rd_val = cnt_qv_reg ? cnt_q_reg : '0;

    assign status.op       = op_reg;
    assign status.hit      = (tstate_reg[ptr_reg] == rrtp_pkg::TS_READY);
    assign status.last     = (off_reg == ntask_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    // Request capture.
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg   <= rrtp_pkg::opcode_t'(s_opcode);
            tidx_reg <= s_task_index;
            nst_reg  <= s_new_state;
        end
    end

    // Task table and scheduler registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rrtp_pkg::MAX_TASKS; i++) begin
                tstate_reg[i] <= (i == 0) ? rrtp_pkg::TS_READY :
                                 (i == 1) ? rrtp_pkg::TS_RUNNING : rrtp_pkg::TS_OTHER;
            end
            cnt_vld_reg <= '0;
            ntask_reg   <= NW'(2);
            cur_reg     <= IW'(1);
            total_reg   <= '0;
            ok_reg      <= 1'b0;
            newidx_reg  <= '0;
            ptr_reg     <= '0;
            off_reg     <= '0;
        end else begin
            if (cmd.take) begin
                ok_reg     <= 1'b0;
                newidx_reg <= '0;
            end
            if (cmd.exec) begin
                unique case (op_reg)
                    rrtp_pkg::OP_ADD: begin
                        if (!table_full) begin
                            tstate_reg[add_idx]  <= rrtp_pkg::TS_READY;
                            cnt_vld_reg[add_idx] <= 1'b0;
                            newidx_reg           <= add_idx;
                            ntask_reg            <= ntask_reg + NW'(1);
                            ok_reg               <= 1'b1;
                        end
                    end
                    rrtp_pkg::OP_YIELD: begin
                        // Demote the running current task before the scan.
                        if (have_cur && tstate_reg[cur_reg] == rrtp_pkg::TS_RUNNING) begin
                            tstate_reg[cur_reg] <= rrtp_pkg::TS_READY;
                        end
                        ptr_reg <= cur_after;
                        off_reg <= NW'(1);
                    end
                    rrtp_pkg::OP_SET: begin
                        if (set_in_range) begin
                            tstate_reg[set_idx] <= set_val;
                            ok_reg              <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.scan_step) begin
                if (status.hit) begin
                    tstate_reg[ptr_reg] <= rrtp_pkg::TS_RUNNING;
                    cur_reg             <= ptr_reg;
                    ok_reg              <= 1'b1;
                end else if (status.last) begin
                    // Nothing ready: restore the old task.
                    if (have_cur) begin
                        tstate_reg[cur_reg] <= rrtp_pkg::TS_RUNNING;
                    end
                end else begin
                    ptr_reg <= ptr_after;
                    off_reg <= off_reg + NW'(1);
                end
            end
            if (cmd.bump_wr) begin
                cnt_vld_reg[cur_reg] <= 1'b1;
                total_reg            <= total_reg + CW'(1);
            end
        end
    end

    // Pick counter memory: one port, registered read.
    always_ff @(posedge aclk) begin
        if (cmd.bump_wr) begin
            cnt_mem[cur_reg] <= cnt_rd_val + CW'(1);
        end
        if (cmd.bump_rd || cmd.cnt_rd) begin
            cnt_q_reg  <= cnt_mem[cur_reg];
            cnt_qv_reg <= cnt_vld_reg[cur_reg];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_accepted_reg       <= ok_reg;
            m_current_index_reg  <= rrtp_pkg::OIDX_W'(cur_reg);
            m_num_tasks_reg      <= rrtp_pkg::ONUM_W'(ntask_reg);
            m_new_task_index_reg <= rrtp_pkg::OIDX_W'(newidx_reg);
            m_yield_total_reg    <= total_reg;
            m_picked_count_reg   <= cnt_rd_val;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_accepted       = m_accepted_reg;
    assign m_current_index  = m_current_index_reg;
    assign m_num_tasks      = m_num_tasks_reg;
    assign m_new_task_index = m_new_task_index_reg;
    assign m_yield_total    = m_yield_total_reg;
    assign m_picked_count   = m_picked_count_reg;

endmodule

@@ hdl/round_robin_task_picker.sv @@
// Round-robin task picker: top level joining rrtp_ctrl and rrtp_datapath.
// Depends on rrtp_pkg and round_robin_task_picker_defines.svh.
//
// Usage: each request on the s_ channel (opcode, task_index, new_state) yields
// exactly one result on the m_ channel. Add registers a ready task, set-state
// rewrites one registered entry, yield hands the processor to the next ready
// task after the current one, wrapping round the registered entries.
// Requests are handled one at a time. Add, set-state and the unused opcode
// go through the exec, counter-read and response states before m_valid
// rises. After exec, a yield inspects 1 up to the number of registered
// tasks table entries, one per cycle; if it picks a task it reads and writes
// its pick counter, then both kinds of yield do the counter read and respond.
// The result sits in an output register: the next request is taken in the
// cycle after the result is loaded, while it still waits for m_ready. If the
// receiver stalls longer, hold the finished result of the following request
// inside until the output register frees up; s_ready stays low meanwhile.
// Reset (aresetn low at a clock edge) restores the initial table: entry 0
// ready, entry 1 running and current, two tasks registered, all counters zero.
`timescale 1ns / 1ps
`include "round_robin_task_picker_defines.svh"

module round_robin_task_picker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rrtp_pkg::OP_W-1:0]     s_opcode,
    input  logic [rrtp_pkg::TIDX_W-1:0]   s_task_index,
    input  logic [rrtp_pkg::ST_W-1:0]     s_new_state,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_accepted,
    output logic [rrtp_pkg::OIDX_W-1:0]   m_current_index,
    output logic [rrtp_pkg::ONUM_W-1:0]   m_num_tasks,
    output logic [rrtp_pkg::OIDX_W-1:0]   m_new_task_index,
    output logic [rrtp_pkg::CNT_W-1:0]    m_yield_total,
    output logic [rrtp_pkg::CNT_W-1:0]    m_picked_count
);

    // Commands flow from the sequencer, status back from the datapath.
    rrtp_pkg::dp_cmd_t    cmd;
    rrtp_pkg::dp_status_t status;

    rrtp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rrtp_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_opcode         (s_opcode),
        .s_task_index     (s_task_index),
        .s_new_state      (s_new_state),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_accepted       (m_accepted),
        .m_current_index  (m_current_index),
        .m_num_tasks      (m_num_tasks),
        .m_new_task_index (m_new_task_index),
        .m_yield_total    (m_yield_total),
        .m_picked_count   (m_picked_count),
        .cmd              (cmd),
        .status           (status)
    );

    // At most one datapath command per cycle.
    `RRTP_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd), "datapath commands overlap")

    // One request in flight: drop ready right after an accept.
    `RRTP_ASSERT_NEXT(a_single_req, s_valid && s_ready, !s_ready, "second request taken early")

    // A counter write-back always follows its read.
    `RRTP_ASSERT_IMP(a_bump_order, cmd.bump_wr, $past(cmd.bump_rd), "counter write without read")

endmodule

@@ tb/round_robin_task_picker_tb.sv @@
// Self-checking testbench for round_robin_task_picker: directed and random requests
// checked against an in-bench model of the task table. Depends on rrtp_pkg and the RTL.
`timescale 1ns / 1ps

module round_robin_task_picker_tb;

    // One expected or observed result, field for field as on the m_ channel.
    typedef struct packed {
        logic                          accepted;
        logic [rrtp_pkg::OIDX_W-1:0]   current_index;
        logic [rrtp_pkg::ONUM_W-1:0]   num_tasks;
        logic [rrtp_pkg::OIDX_W-1:0]   new_task_index;
        logic [rrtp_pkg::CNT_W-1:0]    yield_total;
        logic [rrtp_pkg::CNT_W-1:0]    picked_count;
    } picker_result_t;

    // Model of the task table plus the queue of results still owed by the block.
    class task_table_tracker;
        rrtp_pkg::task_state_t     slot_state [rrtp_pkg::MAX_TASKS];
        bit [rrtp_pkg::CNT_W-1:0]  slot_picks [rrtp_pkg::MAX_TASKS];
        int unsigned               live_tasks;
        int unsigned               cur_slot;
        bit [rrtp_pkg::CNT_W-1:0]  pick_total;
        picker_result_t            owed_results [$];
        int unsigned               failures;

        function new();
            foreach (slot_state[i]) begin
                slot_state[i] = rrtp_pkg::TS_OTHER;
                slot_picks[i] = '0;
            end
            slot_state[0] = rrtp_pkg::TS_READY;
            slot_state[1] = rrtp_pkg::TS_RUNNING;
            live_tasks    = 2;
            cur_slot      = 1;
            pick_total    = '0;
            failures      = 0;
        endfunction

        function void note_request(rrtp_pkg::opcode_t op,
                                   logic [rrtp_pkg::TIDX_W-1:0] idx,
                                   logic [rrtp_pkg::ST_W-1:0] st);
            picker_result_t exp;
            bit             ok;
            bit             have_cur;
            bit             found;
            int unsigned    new_idx;
            int unsigned    probe;
            ok       = 1'b0;
            found    = 1'b0;
            have_cur = 1'b0;
            new_idx  = 0;
            case (op)
                rrtp_pkg::OP_ADD: begin
                    if (live_tasks < rrtp_pkg::MAX_TASKS) begin
                        new_idx             = live_tasks;
                        slot_state[new_idx] = rrtp_pkg::TS_READY;
                        slot_picks[new_idx] = '0;
                        live_tasks++;
                        ok = 1'b1;
                    end
                end
                rrtp_pkg::OP_YIELD: begin
                    if (live_tasks != 0) begin
                        have_cur = cur_slot < live_tasks;
                        if (have_cur && slot_state[cur_slot] == rrtp_pkg::TS_RUNNING)
                            slot_state[cur_slot] = rrtp_pkg::TS_READY;
                        // Scan circularly from the entry after the current one.
                        for (int unsigned off = 1; off <= live_tasks && !found; off++) begin
                            probe = (cur_slot + off) % live_tasks;
                            if (slot_state[probe] == rrtp_pkg::TS_READY) begin
                                found = 1'b1;
                                cur_slot = probe;
                                slot_state[probe] = rrtp_pkg::TS_RUNNING;
                                slot_picks[probe] = slot_picks[probe] + 1;
                                pick_total = pick_total + 1;
                            end
                        end
                        if (found)
                            ok = 1'b1;
                        else if (have_cur)
                            slot_state[cur_slot] = rrtp_pkg::TS_RUNNING;
                    end
                end
                rrtp_pkg::OP_SET: begin
                    if (idx < live_tasks) begin
                        slot_state[idx] = (st > rrtp_pkg::TS_OTHER) ? rrtp_pkg::TS_OTHER
                                                                    : rrtp_pkg::task_state_t'(st);
                        ok = 1'b1;
                    end
                end
                default: ;
            endcase
            exp.accepted       = ok;
            exp.current_index  = cur_slot[rrtp_pkg::OIDX_W-1:0];
            exp.num_tasks      = live_tasks[rrtp_pkg::ONUM_W-1:0];
            exp.new_task_index = new_idx[rrtp_pkg::OIDX_W-1:0];
            exp.yield_total    = pick_total;
            exp.picked_count   = slot_picks[cur_slot];
            owed_results.push_back(exp);
        endfunction

        function void compare_field(string field, logic [rrtp_pkg::CNT_W-1:0] exp,
                                    logic [rrtp_pkg::CNT_W-1:0] got);
            if (got !== exp) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, got);
                failures++;
            end
        endfunction

        function void check_result(picker_result_t got);
            picker_result_t exp;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                failures++;
                return;
            end
            exp = owed_results.pop_front();
            compare_field("accepted", exp.accepted, got.accepted);
            compare_field("current_index", exp.current_index, got.current_index);
            compare_field("num_tasks", exp.num_tasks, got.num_tasks);
            compare_field("new_task_index", exp.new_task_index, got.new_task_index);
            compare_field("yield_total", exp.yield_total, got.yield_total);
            compare_field("picked_count", exp.picked_count, got.picked_count);
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [rrtp_pkg::OP_W-1:0]      s_opcode = '0;
    logic [rrtp_pkg::TIDX_W-1:0]    s_task_index = '0;
    logic [rrtp_pkg::ST_W-1:0]      s_new_state = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_accepted;
    logic [rrtp_pkg::OIDX_W-1:0]    m_current_index;
    logic [rrtp_pkg::ONUM_W-1:0]    m_num_tasks;
    logic [rrtp_pkg::OIDX_W-1:0]    m_new_task_index;
    logic [rrtp_pkg::CNT_W-1:0]     m_yield_total;
    logic [rrtp_pkg::CNT_W-1:0]     m_picked_count;

    // Percentages of cycles in which each side holds off; changed per phase.
    int unsigned send_idle_pct = 29;
    int unsigned recv_idle_pct = 45;

    task_table_tracker tracker = new();

    round_robin_task_picker u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_task_index     (s_task_index),
        .s_new_state      (s_new_state),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_current_index  (m_current_index),
        .m_num_tasks      (m_num_tasks),
        .m_new_task_index (m_new_task_index),
        .m_yield_total    (m_yield_total),
        .m_picked_count   (m_picked_count)
    );

    // 8 ns clock: four high, four low.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver back-pressure: drop m_ready at random for the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Observe both channels at the edge. Everything here reads the values that
    // stood before the edge, since all drivers and the block update by NBA.
    always @(posedge aclk) begin
        picker_result_t seen;
        if (aresetn) begin
            if (s_valid && s_ready)
                tracker.note_request(rrtp_pkg::opcode_t'(s_opcode), s_task_index, s_new_state);
            if (m_valid && m_ready) begin
                seen.accepted       = m_accepted;
                seen.current_index  = m_current_index;
                seen.num_tasks      = m_num_tasks;
                seen.new_task_index = m_new_task_index;
                seen.yield_total    = m_yield_total;
                seen.picked_count   = m_picked_count;
                tracker.check_result(seen);
            end
        end
    end

    // Present one request and hold it until the block takes it. A gap first
    // lowers s_valid; with no gap, valid stays high and only the payload moves.
    task send_request(rrtp_pkg::opcode_t op, logic [rrtp_pkg::TIDX_W-1:0] idx,
                      logic [rrtp_pkg::ST_W-1:0] st);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_task_index <= idx;
        s_new_state  <= st;
        do
            @(posedge aclk);
        while (!(s_ready === 1'b1));
    endtask

    // Random request mix: mostly yields and set-states with a bias towards ready,
    // so the scan keeps finding work; adds and the unused opcode act as noise.
    task send_random_request();
        int unsigned                pick;
        rrtp_pkg::opcode_t          op;
        logic [rrtp_pkg::ST_W-1:0]  st;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = rrtp_pkg::OP_YIELD;
        else if (pick < 85)
            op = rrtp_pkg::OP_SET;
        else if (pick < 95)
            op = rrtp_pkg::OP_ADD;
        else
            op = rrtp_pkg::OP_NONE;
        if ($urandom_range(0, 1) == 0)
            st = rrtp_pkg::TS_READY;
        else
            st = rrtp_pkg::ST_W'($urandom_range(0, 3));
        send_request(op, rrtp_pkg::TIDX_W'($urandom_range(0, 15)), st);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, starting from the post-reset table (0 ready, 1 running).
        send_request(rrtp_pkg::OP_YIELD, 4'd0, rrtp_pkg::TS_READY);   // pick entry 0
        send_request(rrtp_pkg::OP_YIELD, 4'd15, rrtp_pkg::TS_OTHER);  // back to entry 1
        send_request(rrtp_pkg::OP_SET, 4'd15, rrtp_pkg::TS_READY);    // index far out of range
        send_request(rrtp_pkg::OP_SET, 4'd2, rrtp_pkg::TS_READY);     // index one past the end
        send_request(rrtp_pkg::OP_SET, 4'd0, 2'b11);        // state code three stored as other
        send_request(rrtp_pkg::OP_YIELD, 4'd0, rrtp_pkg::TS_READY);   // only current ready
        send_request(rrtp_pkg::OP_SET, 4'd1, rrtp_pkg::TS_OTHER);
        send_request(rrtp_pkg::OP_YIELD, 4'd0, rrtp_pkg::TS_READY);   // nothing ready
        send_request(rrtp_pkg::OP_NONE, 4'd15, 2'b11);                // unused opcode
        send_request(rrtp_pkg::OP_SET, 4'd0, rrtp_pkg::TS_READY);
        // Fill the table, then add once more against a full table.
        repeat (rrtp_pkg::MAX_TASKS - 2)
            send_request(rrtp_pkg::OP_ADD, rrtp_pkg::TIDX_W'($urandom_range(0, 15)),
                         rrtp_pkg::ST_W'($urandom_range(0, 3)));
        send_request(rrtp_pkg::OP_ADD, 4'd0, rrtp_pkg::TS_READY);
        send_request(rrtp_pkg::OP_SET, 4'd15, rrtp_pkg::TS_READY);    // last entry of a full table
        send_request(rrtp_pkg::OP_YIELD, 4'd0, rrtp_pkg::TS_READY);

        // Random part in three phases of back-pressure.
        repeat (400) send_random_request();
        send_idle_pct = 45;
        recv_idle_pct = 29;
        repeat (400) send_random_request();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (400) send_random_request();
        s_valid <= 1'b0;

        // Drain: wait for every owed result, then allow a few slow yields' worth.
        while (tracker.owed_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (tracker.failures == 0)
            $display("[round_robin_task_picker] OK");
        else
            $display("[round_robin_task_picker] ERROR");
        $finish;
    end

    // Watchdog: several times the slowest plausible run.
    initial begin
        #4_000_000;
        $display("[round_robin_task_picker] ERROR");
        $finish;
    end

endmodule
